FILE: hdl/rmd_pkg.sv
// Shared types, constants and the script prefix table of the RTMP message router.
package rmd_pkg;

	localparam int QueueDepthDefault = 4;

	localparam logic [7:0] TypeAudio     = 8'd8;
	localparam logic [7:0] TypeVideo     = 8'd9;
	localparam logic [7:0] TypeScript    = 8'd18;
	localparam logic [7:0] TypeScriptAmf3 = 8'd15;
	localparam logic [7:0] TypeCommand   = 8'd20;
	localparam logic [7:0] TypeFlexCmd   = 8'd17;
	localparam logic [7:0] TypeUserEvent = 8'd4;
	localparam logic [7:0] TypeAggregate = 8'd22;

	localparam logic [2:0] RouteAudio   = 3'd0;
	localparam logic [2:0] RouteVideo   = 3'd1;
	localparam logic [2:0] RouteScript  = 3'd2;
	localparam logic [2:0] RouteCommand = 3'd3;
	localparam logic [2:0] RouteEvent   = 3'd4;
	localparam logic [2:0] RouteControl = 3'd5;
	localparam logic [2:0] RouteNone    = 3'd7;

	localparam logic [3:0] HdrLast     = 4'd10;
	localparam logic [3:0] HdrLenIdx   = 4'd3;
	localparam logic [3:0] PtrLen      = 4'd4;
	localparam logic [4:0] PrefixLen   = 5'd16;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        msg_start;
		logic [7:0]  msg_type;
		logic [23:0] msg_length;
		logic [31:0] msg_timestamp;
	} in_t;

	typedef struct packed {
		logic [2:0]  route;
		logic [7:0]  out_byte;
		logic [31:0] out_timestamp;
		logic [23:0] out_length;
		logic        first_of_msg;
		logic        last_of_msg;
		logic        overrun_error;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic [3:0] replay;
		out_t       res;
	} cmd_t;

	function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:  r = 8'h02;
			4'd1:  r = 8'h00;
			4'd2:  r = 8'h0d;
			4'd3:  r = 8'h40;
			4'd4:  r = 8'h73;
			4'd5:  r = 8'h65;
			4'd6:  r = 8'h74;
			4'd7:  r = 8'h44;
			4'd8:  r = 8'h61;
			4'd9:  r = 8'h74;
			4'd10: r = 8'h61;
			4'd11: r = 8'h46;
			4'd12: r = 8'h72;
			4'd13: r = 8'h61;
			4'd14: r = 8'h6d;
			default: r = 8'h65;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] route_of(input logic [7:0] t);
		logic [2:0] r;
		case (t)
			TypeAudio: r = RouteAudio;
			TypeVideo: r = RouteVideo;
			TypeScript, TypeScriptAmf3: r = RouteScript;
			TypeCommand, TypeFlexCmd: r = RouteCommand;
			TypeUserEvent: r = RouteEvent;
			8'd1, 8'd2, 8'd3, 8'd5, 8'd6: r = RouteControl;
			default: r = RouteNone;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/rmd_front.sv
// Front end: parses each body byte, tracks message state and issues result commands.
module rmd_front import rmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic acc,
	input  in_t  item,
	output logic push,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_PASS   = 7'b0000010,
		PH_SCRIPT = 7'b0000100,
		PH_AHDR   = 7'b0001000,
		PH_ABODY  = 7'b0010000,
		PH_APTR   = 7'b0100000,
		PH_DROP   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       emit;
		logic [4:0] pm;
		cmd_t       cmd;
	} scr_t;

	phase_t      phase_q, nph;
	logic [7:0]  cur_type_q, typ, sub_type_q, styp;
	logic [23:0] body_length_q, blen, body_offset_q, boff;
	logic [23:0] sub_length_q, slen, sub_remaining_q, srem, pos;
	logic [3:0]  header_index_q, hidx;
	logic [31:0] sub_raw_time_q, sraw, prev_raw_time_q, prev, running_time_q, rt;
	logic [4:0]  prefix_matched_q, pm;
	logic [7:0]  b;
	scr_t        sr;

	function automatic scr_t script_fn(input logic [7:0] bt, input logic [23:0] len,
			input logic [23:0] p, input logic [4:0] m, input logic [31:0] ts);
		scr_t r;
		r = '0;
		r.pm = m;
		r.cmd.res.route = RouteScript;
		r.cmd.res.out_byte = bt;
		r.cmd.res.out_timestamp = ts;
		r.cmd.res.out_length = len;
		r.cmd.res.first_of_msg = (p == 24'd0);
		r.cmd.res.last_of_msg = ({1'b0, p} + 25'd1 == {1'b0, len});
		if (len <= 24'd16) begin
			r.emit = 1'b1;
		end else if (p < 24'd16 && m == p[4:0]) begin
			if (bt == prefix_byte(p[3:0])) begin
				r.pm = p[4:0] + 5'd1;
			end else begin
				r.emit = 1'b1;
				r.cmd.replay = p[3:0];
			end
		end else if (m == PrefixLen) begin
			r.emit = 1'b1;
			r.cmd.res.out_length = len - 24'd16;
			r.cmd.res.first_of_msg = (p == 24'd16);
		end else begin
			r.emit = 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		nph = phase_q;
		typ = cur_type_q;
		blen = body_length_q;
		boff = body_offset_q;
		hidx = header_index_q;
		styp = sub_type_q;
		slen = sub_length_q;
		srem = sub_remaining_q;
		sraw = sub_raw_time_q;
		prev = prev_raw_time_q;
		rt = running_time_q;
		pm = prefix_matched_q;
		b = item.payload_byte;
		push = 1'b0;
		cmd = '0;
		pos = '0;
		sr = '0;
		if (item.msg_start) begin
			typ = item.msg_type;
			blen = item.msg_length;
			rt = item.msg_timestamp;
			boff = '0;
			pm = '0;
			prev = '0;
			hidx = '0;
			if (blen == 24'd0) begin
				nph = PH_IDLE;
			end else if (typ == TypeAggregate) begin
				nph = (26'd15 < {2'b0, blen}) ? PH_AHDR : PH_DROP;
			end else if (typ == TypeScript || typ == TypeScriptAmf3) begin
				nph = PH_SCRIPT;
			end else if (route_of(typ) != RouteNone) begin
				nph = PH_PASS;
			end else begin
				nph = PH_DROP;
			end
		end
		unique case (nph)
			PH_PASS: begin
				cmd.res.route = route_of(typ);
				cmd.res.out_byte = b;
				cmd.res.out_timestamp = rt;
				cmd.res.last_of_msg = ({1'b0, boff} + 25'd1 == {1'b0, blen});
				if (typ == TypeFlexCmd) begin
					push = (boff != 24'd0);
					cmd.res.out_length = blen - 24'd1;
					cmd.res.first_of_msg = (boff == 24'd1);
				end else begin
					push = 1'b1;
					cmd.res.out_length = blen;
					cmd.res.first_of_msg = (boff == 24'd0);
				end
			end
			PH_SCRIPT: begin
				sr = script_fn(b, blen, boff, pm, rt);
				push = sr.emit;
				cmd = sr.cmd;
				pm = sr.pm;
			end
			PH_AHDR: begin
				case (hidx)
					4'd0: styp = b;
					4'd1: slen = {b, 16'h0};
					4'd2: slen = slen | {8'h0, b, 8'h0};
					4'd3: slen = slen | {16'h0, b};
					4'd4: sraw = {8'h0, b, 16'h0};
					4'd5: sraw = sraw | {16'h0, b, 8'h0};
					4'd6: sraw = sraw | {24'h0, b};
					4'd7: sraw = sraw | {b, 24'h0};
					default: ;
				endcase
				if (hidx == HdrLenIdx &&
						({2'b0, boff} - 26'd3 + {2'b0, slen} + 26'd15 > {2'b0, blen})) begin
					push = 1'b1;
					cmd.res.overrun_error = 1'b1;
					nph = PH_DROP;
				end else if (hidx == HdrLast) begin
					if (boff != 24'd10) begin
						rt = rt + sraw - prev;
					end
					prev = sraw;
					hidx = '0;
					pm = '0;
					if (slen == 24'd0) begin
						nph = PH_APTR;
					end else begin
						srem = slen;
						nph = PH_ABODY;
					end
				end else begin
					hidx = hidx + 4'd1;
				end
			end
			PH_ABODY: begin
				pos = slen - srem;
				if (styp == TypeAudio || styp == TypeVideo) begin
					push = 1'b1;
					cmd.res.route = {2'b0, styp[0]};
					cmd.res.out_byte = b;
					cmd.res.out_timestamp = rt;
					cmd.res.out_length = slen;
					cmd.res.first_of_msg = (pos == 24'd0);
					cmd.res.last_of_msg = ({1'b0, pos} + 25'd1 == {1'b0, slen});
				end else if (styp == TypeScript) begin
					sr = script_fn(b, slen, pos, pm, rt);
					push = sr.emit;
					cmd = sr.cmd;
					pm = sr.pm;
				end
				srem = srem - 24'd1;
				if (srem == 24'd0) begin
					hidx = '0;
					nph = PH_APTR;
				end
			end
			PH_APTR: begin
				hidx = hidx + 4'd1;
				if (hidx >= PtrLen) begin
					hidx = '0;
					nph = ({2'b0, boff} + 26'd16 < {2'b0, blen}) ? PH_AHDR : PH_DROP;
				end
			end
			PH_IDLE, PH_DROP: ;
			default: ;
		endcase
		if (nph != PH_IDLE) begin
			boff = boff + 24'd1;
			if (boff >= blen) begin
				nph = PH_IDLE;
			end
		end
		push = push & acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_type_q <= '0;
			body_length_q <= '0;
			body_offset_q <= '0;
			header_index_q <= '0;
			sub_type_q <= '0;
			sub_length_q <= '0;
			sub_remaining_q <= '0;
			sub_raw_time_q <= '0;
			prev_raw_time_q <= '0;
			running_time_q <= '0;
			prefix_matched_q <= '0;
		end else if (acc) begin
			phase_q <= nph;
			cur_type_q <= typ;
			body_length_q <= blen;
			body_offset_q <= boff;
			header_index_q <= hidx;
			sub_type_q <= styp;
			sub_length_q <= slen;
			sub_remaining_q <= srem;
			sub_raw_time_q <= sraw;
			prev_raw_time_q <= prev;
			running_time_q <= rt;
			prefix_matched_q <= pm;
		end
	end

endmodule

FILE: hdl/rmd_fifo.sv
// Command queue between the parsing front end and the result expander.
module rmd_fifo import rmd_pkg::*; #(
	parameter int Depth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
		end
	end

endmodule

FILE: hdl/rmd_back.sv
// Back end: expands queued commands into result transfers, replaying prefix bytes.
module rmd_back import rmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cmd_t head,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output out_t res_data
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	out_t       out_q, nxt;
	logic       take, replay;

	assign take = !out_valid_q || !res_stall;
	assign replay = (idx_q < head.replay);
	assign pop = take && head_valid && !replay;
	assign res_valid = out_valid_q;
	assign res_data = out_q;

	always_comb begin
		nxt = head.res;
		nxt.last_of_run = 1'b1;
		if (replay) begin
			nxt.route = RouteScript;
			nxt.out_byte = prefix_byte(idx_q);
			nxt.first_of_msg = (idx_q == 4'd0);
			nxt.last_of_msg = 1'b0;
			nxt.overrun_error = 1'b0;
			nxt.last_of_run = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && head_valid) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= replay ? idx_q + 4'd1 : '0;
			end
		end
	end

endmodule

FILE: hdl/rtmp_message_router_deaggregator_core.sv
// Top level of the RTMP message router and aggregate splitter.
//
//   channel  | handshake                  | payload
//   input    | byte_valid / byte_stall    | byte_data (in_t)
//   results  | res_valid / res_stall      | res_data (out_t)
//
// An input byte is taken every cycle while the command queue has room.
// Each byte is parsed in the cycle it is taken; its results leave one per cycle while
// res_stall is low, so a script prefix mismatch that replays k bytes emits those k bytes
// and then the mismatching byte. Results pass through the queue and the output register.
// Reset clears all message state and empties the queue.
module rtmp_message_router_deaggregator_core import rmd_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_stall,
	input  in_t  byte_data,
	output logic res_valid,
	input  logic res_stall,
	output out_t res_data
);

	logic acc, push, full, pop, head_valid;
	cmd_t cmd, head;

	assign byte_stall = full;
	assign acc = byte_valid && !full;

	rmd_front u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .item(byte_data), .push(push), .cmd(cmd)
	);

	rmd_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(cmd), .full(full),
		.pop(pop), .head_valid(head_valid), .head(head)
	);

	rmd_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head), .pop(pop),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command pushed into a full queue");
	a_ovr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.overrun_error |-> res_data.last_of_run &&
		res_data.out_byte == 8'd0 && res_data.out_length == 24'd0)
		else $error("overrun result carries data");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from an empty queue");
	a_replay_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last_of_run |-> res_data.route == RouteScript)
		else $error("non-final result outside a script replay");
`endif

endmodule

FILE: tb/rtmp_message_router_deaggregator_core_checker.sv
// Checker for the RTMP message router: predicts results of each input transfer and compares them.
`timescale 1ns / 100ps
module rtmp_message_router_deaggregator_core_checker import rmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	input  logic byte_stall,
	input  in_t  byte_data,
	input  logic res_valid,
	input  logic res_stall,
	input  out_t res_data,
	output int   failures,
	output int   pending
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_PASS, PH_SCRIPT, PH_AHDR, PH_ABODY, PH_APTR, PH_DROP
	} phase_t;

	localparam logic [7:0] ErrFree = 8'd0;

	logic [7:0]  cur_type;
	logic [23:0] body_len, body_off, sub_len, sub_rem;
	logic [3:0]  hdr_idx;
	logic [7:0]  sub_type;
	logic [31:0] sub_raw, prev_raw, run_time;
	logic [4:0]  matched;
	phase_t      phase;
	out_t        expected_results[$];
	out_t        step_results[$];

	assign pending = expected_results.size();

	function automatic logic [2:0] route_for(input logic [7:0] t);
		case (t)
			TypeAudio: return RouteAudio;
			TypeVideo: return RouteVideo;
			TypeScript, TypeScriptAmf3: return RouteScript;
			TypeCommand, TypeFlexCmd: return RouteCommand;
			TypeUserEvent: return RouteEvent;
			8'd1, 8'd2, 8'd3, 8'd5, 8'd6: return RouteControl;
			default: return RouteNone;
		endcase
	endfunction

	function automatic logic [7:0] setdata_byte(input int k);
		logic [7:0] tab[16];
		tab = '{8'h02, 8'h00, 8'h0d, 8'h40, 8'h73, 8'h65, 8'h74, 8'h44,
			8'h61, 8'h74, 8'h61, 8'h46, 8'h72, 8'h61, 8'h6d, 8'h65};
		return tab[k];
	endfunction

	task automatic push_result(input logic [2:0] rt, input logic [7:0] b,
		input logic [23:0] len, input logic fst, input logic lst, input logic ovr);
		out_t r;
		r.route = rt;
		r.out_byte = b;
		r.out_timestamp = ovr ? 32'd0 : run_time;
		r.out_length = len;
		r.first_of_msg = fst;
		r.last_of_msg = lst;
		r.overrun_error = ovr;
		r.last_of_run = 1'b0;
		step_results.push_back(r);
	endtask

	task automatic script_byte(input logic [7:0] b, input logic [23:0] len,
		input logic [23:0] pos);
		logic lst;
		lst = (pos + 24'd1 == len);
		if (len <= 24'd16) begin
			push_result(RouteScript, b, len, pos == 0, lst, 1'b0);
		end else if (pos < 24'd16 && matched == pos[4:0]) begin
			if (b == setdata_byte(pos[3:0])) begin
				matched = pos[4:0] + 5'd1;
			end else begin
				for (int k = 0; k < pos; k++)
					push_result(RouteScript, setdata_byte(k), len, k == 0, 1'b0, 1'b0);
				push_result(RouteScript, b, len, pos == 0, lst, 1'b0);
			end
		end else if (matched == 5'd16) begin
			push_result(RouteScript, b, len - 24'd16, pos == 24'd16, lst, 1'b0);
		end else begin
			push_result(RouteScript, b, len, pos == 0, lst, 1'b0);
		end
	endtask

	task automatic begin_sub(input logic [23:0] at);
		hdr_idx = 0;
		phase = (32'(at) + 32'd15 < 32'(body_len)) ? PH_AHDR : PH_DROP;
	endtask

	task automatic predict_byte(input in_t it);
		logic [7:0] b;
		logic [23:0] pos;
		b = it.payload_byte;
		step_results.delete();
		if (it.msg_start) begin
			cur_type = it.msg_type;
			body_len = it.msg_length;
			run_time = it.msg_timestamp;
			body_off = 0;
			matched = 0;
			prev_raw = 0;
			hdr_idx = 0;
			if (body_len == 0) begin
				phase = PH_IDLE;
				return;
			end
			if (cur_type == TypeAggregate) begin_sub(24'd0);
			else if (cur_type == TypeScript || cur_type == TypeScriptAmf3) phase = PH_SCRIPT;
			else if (route_for(cur_type) != RouteNone) phase = PH_PASS;
			else phase = PH_DROP;
		end
		case (phase)
			PH_PASS: begin
				if (cur_type == TypeFlexCmd) begin
					if (body_off != 0)
						push_result(RouteCommand, b, body_len - 24'd1, body_off == 24'd1,
							body_off + 24'd1 == body_len, 1'b0);
				end else begin
					push_result(route_for(cur_type), b, body_len, body_off == 0,
						body_off + 24'd1 == body_len, 1'b0);
				end
			end
			PH_SCRIPT: script_byte(b, body_len, body_off);
			PH_AHDR: begin
				case (hdr_idx)
					4'd0: sub_type = b;
					4'd1: sub_len = {b, 16'd0};
					4'd2: sub_len[15:8] = b;
					4'd3: sub_len[7:0] = b;
					4'd4: sub_raw = {8'd0, b, 16'd0};
					4'd5: sub_raw[15:8] = b;
					4'd6: sub_raw[7:0] = b;
					4'd7: sub_raw[31:24] = b;
					default: ;
				endcase
				if (hdr_idx == HdrLenIdx && 33'(body_off - 24'd3) + 33'(sub_len) + 33'd15
						> 33'(body_len)) begin
					push_result(RouteAudio, ErrFree, 24'd0, 1'b0, 1'b0, 1'b1);
					phase = PH_DROP;
				end else if (hdr_idx == HdrLast) begin
					if (body_off != 24'd10) run_time += sub_raw - prev_raw;
					prev_raw = sub_raw;
					hdr_idx = 0;
					matched = 0;
					if (sub_len == 0) begin
						phase = PH_APTR;
					end else begin
						sub_rem = sub_len;
						phase = PH_ABODY;
					end
				end else begin
					hdr_idx = hdr_idx + 4'd1;
				end
			end
			PH_ABODY: begin
				pos = sub_len - sub_rem;
				if (sub_type == TypeAudio || sub_type == TypeVideo)
					push_result(sub_type == TypeAudio ? RouteAudio : RouteVideo, b, sub_len,
						pos == 0, pos + 24'd1 == sub_len, 1'b0);
				else if (sub_type == TypeScript)
					script_byte(b, sub_len, pos);
				sub_rem = sub_rem - 24'd1;
				if (sub_rem == 0) begin
					hdr_idx = 0;
					phase = PH_APTR;
				end
			end
			PH_APTR: begin
				hdr_idx = hdr_idx + 4'd1;
				if (hdr_idx >= PtrLen) begin_sub(body_off + 24'd1);
			end
			default: ;
		endcase
		if (phase != PH_IDLE) begin
			body_off = body_off + 24'd1;
			if (body_off >= body_len) phase = PH_IDLE;
		end
		if (step_results.size() > 0) step_results[$].last_of_run = 1'b1;
		foreach (step_results[i]) expected_results.push_back(step_results[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			cur_type = 0; body_len = 0; body_off = 0; sub_len = 0; sub_rem = 0;
			hdr_idx = 0; sub_type = 0; sub_raw = 0; prev_raw = 0; run_time = 0;
			matched = 0; phase = PH_IDLE;
			expected_results.delete();
			failures = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("Unexpected result transfer: %p", res_data);
				end else begin
					want = expected_results.pop_front();
					if (res_data !== want) begin
						failures++;
						if (failures <= 10)
							$display("Mismatch: expected %p, got %p", want, res_data);
					end
				end
			end
			if (byte_valid && !byte_stall) predict_byte(byte_data);
		end
	end

endmodule

FILE: tb/rtmp_message_router_deaggregator_core_tb.sv
// Testbench top for the RTMP message router: drives byte streams and gives the verdict.
`timescale 1ns / 100ps
module rtmp_message_router_deaggregator_core_tb;
	import rmd_pkg::*;

	logic clk, arst_n;
	logic byte_valid, byte_stall, res_valid, res_stall;
	in_t  byte_data;
	out_t res_data;
	int   failures, pending;
	int   cycles;
	int   sent;
	bit   calm;

	localparam int CycleLimit = 400000;

	rtmp_message_router_deaggregator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	rtmp_message_router_deaggregator_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.failures(failures), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) res_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);

	task automatic send_byte(input logic [7:0] b, input logic st, input logic [7:0] t,
		input logic [23:0] len, input logic [31:0] ts);
		while (!calm && $urandom_range(99) < 38) begin
			byte_valid <= 1'b0;
			byte_data <= in_t'($urandom());
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{payload_byte: b, msg_start: st, msg_type: t, msg_length: len,
			msg_timestamp: ts};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_plain(input logic [7:0] t, input int len, input int body);
		logic [31:0] ts;
		ts = $urandom();
		for (int i = 0; i < body; i++)
			send_byte(8'($urandom()), i == 0, i == 0 ? t : 8'($urandom()),
				i == 0 ? 24'(len) : 24'($urandom()), i == 0 ? ts : $urandom());
	endtask

	task automatic send_script(input logic [7:0] t, input int len, input int brk);
		logic [31:0] ts;
		logic [7:0] b;
		ts = $urandom();
		for (int i = 0; i < len; i++) begin
			b = (i < 16) ? prefix_byte(i[3:0]) : 8'($urandom());
			if (i == brk) b = b ^ 8'($urandom_range(1, 255));
			send_byte(b, i == 0, t, 24'(len), ts);
		end
	endtask

	task automatic send_aggregate(input int nsub, input bit ovr, input int tail);
		logic [7:0] body[$];
		logic [7:0] st;
		logic [31:0] raw;
		int sl, total;
		logic [31:0] ts;
		for (int s = 0; s < nsub; s++) begin
			case ($urandom_range(4))
				0: st = TypeAudio;
				1: st = TypeVideo;
				2, 3: st = TypeScript;
				default: st = 8'($urandom());
			endcase
			sl = $urandom_range(0, 20);
			raw = $urandom();
			body.push_back(st);
			body.push_back(8'(sl >> 16));
			body.push_back(8'(sl >> 8));
			body.push_back(8'(sl));
			body.push_back(raw[23:16]);
			body.push_back(raw[15:8]);
			body.push_back(raw[7:0]);
			body.push_back(raw[31:24]);
			repeat (3) body.push_back(8'($urandom()));
			for (int i = 0; i < sl; i++)
				body.push_back((st == TypeScript && i < 16 && $urandom_range(3) != 0) ?
					prefix_byte(i[3:0]) : 8'($urandom()));
			repeat (4) body.push_back(8'($urandom()));
		end
		repeat (tail) body.push_back(8'($urandom()));
		total = body.size();
		if (ovr) begin
			body.push_back(TypeVideo);
			body.push_back(8'hff);
			body.push_back(8'hff);
			body.push_back(8'hff);
			repeat (12) body.push_back(8'($urandom()));
			total = body.size();
		end
		ts = $urandom();
		foreach (body[i]) send_byte(body[i], i == 0, TypeAggregate, 24'(total), ts);
	endtask

	initial begin
		int kind;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		sent = 0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'hff, 1'b0, 8'hff, 24'hffffff, 32'hffffffff);
		send_plain(TypeAudio, 1, 1);
		send_plain(TypeVideo, 3, 3);
		send_plain(TypeFlexCmd, 1, 1);
		send_plain(TypeFlexCmd, 3, 3);
		send_plain(TypeCommand, 2, 2);
		send_plain(TypeUserEvent, 1, 1);
		send_plain(8'd6, 1, 1);
		send_plain(8'd19, 1, 1);
		send_plain(TypeAudio, 0, 1);
		send_byte(8'h00, 1'b1, TypeVideo, 24'hffffff, 32'hffffffff);
		send_byte(8'h5a, 1'b0, 8'h00, 24'h000000, 32'h00000000);
		send_plain(TypeAudio, 2, 3);

		while (sent < 250) begin
			kind = $urandom_range(9);
			calm = (sent > 120 && sent < 170);
			case (kind)
				0: send_plain(8'($urandom_range(0, 24)), $urandom_range(0, 5),
					$urandom_range(1, 6));
				1, 2: send_script($urandom_range(1) ? TypeScript : TypeScriptAmf3,
					$urandom_range(14, 22), $urandom_range(0, 24));
				3, 4, 5: send_aggregate($urandom_range(1, 3), 1'b0, 0);
				6: send_aggregate($urandom_range(0, 2), 1'b1, 0);
				7: send_aggregate($urandom_range(1, 2), 1'b0, $urandom_range(1, 15));
				8: send_plain(TypeFlexCmd, $urandom_range(1, 4), $urandom_range(1, 4));
				default: begin
					byte_valid <= 1'b0;
					while (pending != 0) @(posedge clk);
					repeat (4) @(posedge clk);
				end
			endcase
		end
		byte_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rmd_pkg.sv
hdl/rmd_front.sv
hdl/rmd_fifo.sv
hdl/rmd_back.sv
hdl/rtmp_message_router_deaggregator_core.sv
tb/rtmp_message_router_deaggregator_core_checker.sv
tb/rtmp_message_router_deaggregator_core_tb.sv
